/* hdl/tcp_stream_reassembly_defines.svh */
// Assertion macros used by the reassembly back end.
`ifndef TCP_STREAM_REASSEMBLY_DEFINES_SVH
`define TCP_STREAM_REASSEMBLY_DEFINES_SVH
`ifndef SYNTHESIS
`define TSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSR_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSR_ASSERT(label, clk, rst_n, prop, msg)
`define TSR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hdl/tsr_pkg.sv */
// Shared types and codes for the TCP stream reassembly block.
package tsr_pkg;
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DESC   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;

    // Control codes carried in the length field of an OP_NONE command.
    localparam logic [15:0] CTL_OPEN    = 16'd0;
    localparam logic [15:0] CTL_SYNACK  = 16'd1;
    localparam logic [15:0] CTL_FOREIGN = 16'd2;

    // Classified operation handed from front to back.
    typedef enum logic [2:0] {
        OP_SEG   = 3'b001,
        OP_FLUSH = 3'b010,
        OP_NONE  = 3'b100
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        dir;
        logic        fin;
        logic        rst;
        logic [31:0] seq;
        logic [31:0] seg_end;
        logic [15:0] len;
        logic [15:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic        overflow;
        logic        dir;
        logic [15:0] handle;
        logic [15:0] length;
        logic [31:0] expected_seq;
        logic        client_done;
        logic        server_done;
        logic        last;
    } t_result;
endpackage

/* hdl/tsr_queue.sv */
// Small FIFO between the classifier and the table engine.
module tsr_queue
    import tsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

/* hdl/tsr_front.sv */
// Front end: connection handshake tracking and port classification.
module tsr_front
    import tsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic        i_direction,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic        i_fin_flag,
    input  logic        i_rst_flag,
    input  logic [15:0] i_sender_port,
    input  logic [15:0] i_target_port,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_ack_num,
    input  logic [15:0] i_payload_len,
    input  logic [15:0] i_payload_handle,
    input  logic        i_q_full,
    input  logic        i_busy,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_seq_wr,
    input  logic        i_seq_dir,
    input  logic [31:0] i_seq_val
);
    logic [15:0] r_client_port, r_server_port;
    logic [31:0] r_cli_seq;
    logic        take;

    // Handshake writes need the back end drained so next_seq stays coherent.
    assign o_stall = i_q_full || (i_command == CMD_SEGMENT && i_syn_flag && i_busy);
    assign take    = i_valid && !o_stall;
    assign o_push  = take;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.fin     = i_fin_flag;
        o_cmd.rst     = i_rst_flag;
        o_cmd.seq     = i_seq_num;
        o_cmd.seg_end = i_seq_num + {16'd0, i_payload_len};
        o_cmd.len     = i_payload_len;
        o_cmd.handle  = i_payload_handle;
        if (i_command == CMD_FLUSH) begin
            o_cmd.op  = OP_FLUSH;
            o_cmd.dir = i_direction;
        end else if (i_syn_flag) begin
            o_cmd.op  = OP_NONE;
            o_cmd.dir = i_ack_flag;
            o_cmd.fin = i_ack_flag ? 1'b0 : 1'b1; // marks: opening SYN clears
            o_cmd.rst = i_ack_flag && (r_cli_seq + 32'd1 == i_ack_num);
            o_cmd.len = i_ack_flag ? CTL_SYNACK : CTL_OPEN;
        end else if (i_sender_port == r_client_port) begin
            o_cmd.op  = OP_SEG;
            o_cmd.dir = 1'b0;
        end else if (i_sender_port == r_server_port) begin
            o_cmd.op  = OP_SEG;
            o_cmd.dir = 1'b1;
        end else begin
            o_cmd.op  = OP_NONE;
            o_cmd.dir = 1'b0;
            o_cmd.fin = 1'b0;
            o_cmd.rst = 1'b0;
            o_cmd.len = CTL_FOREIGN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port <= '0;
            r_server_port <= '0;
            r_cli_seq     <= '0;
        end else begin
            if (take && i_command == CMD_SEGMENT && i_syn_flag) begin
                if (!i_ack_flag) begin
                    r_client_port <= i_sender_port;
                    r_server_port <= i_target_port;
                    r_cli_seq     <= i_seq_num;
                end else if (r_cli_seq + 32'd1 == i_ack_num) begin
                    r_cli_seq <= r_cli_seq + 32'd1;
                end
            end else if (i_seq_wr && !i_seq_dir) begin
                // Follow the client pointer as the flush walk advances it.
                r_cli_seq <= i_seq_val;
            end
        end
    end
endmodule

/* hdl/tsr_back.sv */
// Back end: descriptor table, flush walk and result register.
`include "tcp_stream_reassembly_defines.svh"
module tsr_back
    import tsr_pkg::*;
#(
    parameter int TableDepth = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_busy,
    output logic    o_seq_wr,
    output logic    o_seq_dir,
    output logic [31:0] o_seq_val,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);
    localparam int IW = $clog2(TableDepth);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIND  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0][TableDepth-1:0] r_valid, n_valid;
    logic [31:0]                r_eseq    [2][TableDepth];
    logic [31:0]                r_eend    [2][TableDepth];
    logic [15:0]                r_ehandle [2][TableDepth];
    logic [15:0]                r_elength [2][TableDepth];
    logic [1:0][31:0]           r_next_seq, n_next_seq;
    logic [1:0]                 r_done, n_done;
    logic                       r_dir, n_dir;
    logic [IW:0]                r_rounds, n_rounds;
    logic [IW-1:0]              r_hit;
    logic [31:0]                r_rd_end;
    logic [15:0]                r_rd_handle, r_rd_length;
    logic                       r_out_valid, n_out_valid;
    t_result                    r_res, n_res;

    logic                  out_free;
    logic                  res_held;
    logic [TableDepth-1:0] match, freev, hitv;
    logic                  have_free, have_hit;
    logic [IW-1:0]         free_idx, hit_idx;
    t_cmd                  c;
    logic                  seg_go, flush_go, tbl_wr;

    assign c           = i_cmd;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign res_held    = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_busy      = i_valid || r_state != ST_IDLE || r_out_valid;

    // Table lane compares for the direction at hand.
    always_comb begin
        for (int i = 0; i < TableDepth; i++) begin
            match[i] = r_valid[c.dir][i] &&
                       (r_eseq[c.dir][i] == c.seq || r_eend[c.dir][i] == c.seg_end);
            freev[i] = !r_valid[c.dir][i] || match[i];
            hitv[i]  = r_valid[r_dir][i] && r_eseq[r_dir][i] == r_next_seq[r_dir];
        end
        have_free = |freev;
        have_hit  = |hitv;
        free_idx  = '0;
        hit_idx   = '0;
        for (int i = TableDepth - 1; i >= 0; i--) begin
            if (freev[i]) free_idx = (IW)'(i);
            if (hitv[i]) hit_idx = (IW)'(i);
        end
    end

    assign seg_go   = r_state == ST_IDLE && i_valid && out_free && c.op != OP_FLUSH;
    assign flush_go = r_state == ST_IDLE && i_valid && c.op == OP_FLUSH;
    assign o_pop    = seg_go || flush_go;
    assign tbl_wr   = seg_go && c.op == OP_SEG && c.len != 16'd0 && have_free;

    // Mirror each flush advance to the front, which keeps a copy of the client pointer.
    assign o_seq_wr  = r_state == ST_EMIT && out_free;
    assign o_seq_dir = r_dir;
    assign o_seq_val = r_rd_end;

    always_comb begin
        logic ovf;
        logic d0, d1;
        n_state     = r_state;
        n_valid     = r_valid;
        n_next_seq  = r_next_seq;
        n_done      = r_done;
        n_dir       = r_dir;
        n_rounds    = r_rounds;
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        ovf = c.len != 16'd0 && !have_free;
        d0  = r_done[0] || c.rst || (c.fin && !c.dir);
        d1  = r_done[1] || c.rst || (c.fin && c.dir);
        unique case (r_state)
            ST_IDLE: begin
                if (flush_go) begin
                    n_dir    = c.dir;
                    n_rounds = '0;
                    n_state  = ST_FIND;
                end else if (seg_go) begin
                    n_out_valid       = 1'b1;
                    n_res             = '0;
                    n_res.kind        = KIND_STATUS;
                    n_res.last        = 1'b1;
                    n_res.client_done = r_done[0];
                    n_res.server_done = r_done[1];
                    if (c.op == OP_SEG) begin
                        // Free retransmitted copies, then take the lowest free entry.
                        if (c.len != 16'd0) begin
                            n_valid[c.dir] = r_valid[c.dir] & ~match;
                            if (have_free) n_valid[c.dir][free_idx] = 1'b1;
                        end
                        n_done             = {d1, d0};
                        n_res.accepted     = 1'b1;
                        n_res.overflow     = ovf;
                        n_res.dir          = c.dir;
                        n_res.expected_seq = r_next_seq[c.dir];
                        n_res.client_done  = d0;
                        n_res.server_done  = d1;
                    end else if (c.len == CTL_OPEN) begin
                        // Opening SYN.
                        n_next_seq[0]      = c.seq;
                        n_next_seq[1]      = '0;
                        n_done             = '0;
                        n_res.accepted     = 1'b1;
                        n_res.dir          = 1'b0;
                        n_res.expected_seq = c.seq;
                        n_res.client_done  = 1'b0;
                        n_res.server_done  = 1'b0;
                    end else if (c.len == CTL_SYNACK) begin
                        // SYN with ACK; accept flag precomputed in front.
                        n_res.accepted = c.rst;
                        n_res.dir      = 1'b1;
                        if (c.rst) begin
                            n_next_seq[0]      = r_next_seq[0] + 32'd1;
                            n_next_seq[1]      = c.seq + 32'd1;
                            n_res.expected_seq = c.seq + 32'd1;
                        end else begin
                            n_res.expected_seq = r_next_seq[1];
                        end
                    end else begin
                        n_res.dir          = 1'b0;
                        n_res.expected_seq = r_next_seq[0];
                    end
                end
            end
            ST_FIND: begin
                if (out_free) begin
                    if (have_hit && r_rounds != (IW+1)'(TableDepth)) begin
                        n_state = ST_READ;
                    end else begin
                        n_out_valid        = 1'b1;
                        n_res              = '0;
                        n_res.kind         = KIND_DONE;
                        n_res.dir          = r_dir;
                        n_res.expected_seq = r_next_seq[r_dir];
                        n_res.client_done  = r_done[0];
                        n_res.server_done  = r_done[1];
                        n_res.last         = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_valid[r_dir][r_hit] = 1'b0;
                    n_next_seq[r_dir]     = r_rd_end;
                    n_rounds              = r_rounds + (IW+1)'(1);
                    n_out_valid           = 1'b1;
                    n_res                 = '0;
                    n_res.kind            = KIND_DESC;
                    n_res.dir             = r_dir;
                    n_res.handle          = r_rd_handle;
                    n_res.length          = r_rd_length;
                    n_res.expected_seq    = r_rd_end;
                    n_res.client_done     = r_done[0];
                    n_res.server_done     = r_done[1];
                    n_state               = ST_FIND;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIND) begin
            r_hit <= hit_idx;
        end
        if (r_state == ST_READ) begin
            r_rd_end    <= r_eend[r_dir][r_hit];
            r_rd_handle <= r_ehandle[r_dir][r_hit];
            r_rd_length <= r_elength[r_dir][r_hit];
        end
        if (tbl_wr) begin
            r_eseq[c.dir][free_idx]    <= c.seq;
            r_eend[c.dir][free_idx]    <= c.seg_end;
            r_ehandle[c.dir][free_idx] <= c.handle;
            r_elength[c.dir][free_idx] <= c.len;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_next_seq  <= '0;
            r_done      <= '0;
            r_dir       <= 1'b0;
            r_rounds    <= '0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_next_seq  <= n_next_seq;
            r_done      <= n_done;
            r_dir       <= n_dir;
            r_rounds    <= n_rounds;
            r_valid     <= n_valid;
        end
    end

    `TSR_ASSERT(a_pop_idle, i_clk, i_rst_n, o_pop |-> r_state == ST_IDLE, "pop outside idle")
    `TSR_ASSERT(a_res_hold, i_clk, i_rst_n, res_held |=> $stable(r_res), "held result moved")
    `TSR_ASSERT(a_desc_last, i_clk, i_rst_n, (r_out_valid && r_res.kind == KIND_DESC) |-> !r_res.last, "descriptor marked last")
    `TSR_ASSERT(a_rounds, i_clk, i_rst_n, r_rounds <= (IW+1)'(TableDepth), "flush rounds overrun")
    `TSR_ASSERT(a_state_hot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
endmodule

/* hdl/tcp_stream_reassembly.sv */
// Top level of the single-connection TCP stream reassembly tracker.
// A segment's status beat is registered in the back end after the command queue.
// Throughput: plain segments 1 beat per cycle unless the output stalls or a flush runs;
// a SYN holds until the back end drains. A flush is dequeued, then searches, reads and
// emits each descriptor in turn, then emits a done beat. Reset is synchronous, active
// low: ports, sequences, end marks and all table valid bits clear; no clearing pass.
module tcp_stream_reassembly
    import tsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic        i_direction,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic        i_fin_flag,
    input  logic        i_rst_flag,
    input  logic [15:0] i_sender_port,
    input  logic [15:0] i_target_port,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_ack_num,
    input  logic [15:0] i_payload_len,
    input  logic [15:0] i_payload_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic        o_accepted,
    output logic        o_overflow,
    output logic        o_out_direction,
    output logic [15:0] o_out_handle,
    output logic [15:0] o_out_length,
    output logic [31:0] o_expected_seq,
    output logic        o_client_done,
    output logic        o_server_done,
    output logic        o_last
);
    logic    q_full, push, pop, q_valid, busy, seq_wr, seq_dir;
    logic [31:0] seq_val;
    t_cmd    f_cmd, q_cmd;
    t_result res;

    // Front: classify the beat against the connection ports.
    tsr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_command, .i_direction, .i_syn_flag, .i_ack_flag, .i_fin_flag,
        .i_rst_flag, .i_sender_port, .i_target_port, .i_seq_num, .i_ack_num,
        .i_payload_len, .i_payload_handle,
        .i_q_full(q_full), .i_busy(busy), .o_push(push), .o_cmd(f_cmd),
        .i_seq_wr(seq_wr), .i_seq_dir(seq_dir), .i_seq_val(seq_val)
    );

    tsr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(f_cmd), .o_full(q_full),
        .i_pop(pop), .o_valid(q_valid), .o_data(q_cmd)
    );

    // Back: own copy of the sequence pointers, table and flush walk.
    tsr_back #(.TableDepth(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_busy(busy), .o_seq_wr(seq_wr), .o_seq_dir(seq_dir), .o_seq_val(seq_val),
        .o_out_valid(o_valid), .i_out_stall(i_stall), .o_res(res)
    );

    assign o_result_kind   = res.kind;
    assign o_accepted      = res.accepted;
    assign o_overflow      = res.overflow;
    assign o_out_direction = res.dir;
    assign o_out_handle    = res.handle;
    assign o_out_length    = res.length;
    assign o_expected_seq  = res.expected_seq;
    assign o_client_done   = res.client_done;
    assign o_server_done   = res.server_done;
    assign o_last          = res.last;
endmodule
